@@ design/integer_to_radix_text_assert.svh @@
// Assertion macros for the radix text converter.
`ifndef INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`define INTEGER_TO_RADIX_TEXT_ASSERT_SVH
`ifndef SYNTH
// Check that a condition implies another in the same cycle.
`define ITRT_ASSERT_SAME(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
    else $error("itrt check failed");
// Check that a condition implies another in the following cycle.
`define ITRT_ASSERT_NEXT(label, clk, rst_n, cond, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
    else $error("itrt check failed");
`else
`define ITRT_ASSERT_SAME(label, clk, rst_n, cond, expr)
`define ITRT_ASSERT_NEXT(label, clk, rst_n, cond, expr)
`endif
`endif

@@ design/itrt_pkg.sv @@
package itrt_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int QUEUE_DEPTH   = 2;

  localparam logic [7:0] RADIX_RESET = 8'd16;
  localparam logic [7:0] RADIX_MIN   = 8'd2;
  localparam logic [7:0] RADIX_MAX   = 8'd16;
  localparam logic [7:0] RADIX_DEC   = 8'd10;

  localparam logic [6:0] ASCII_ZERO   = 7'd48;
  localparam logic [6:0] ASCII_LETTER = 7'd55;
  localparam logic [6:0] ASCII_MINUS  = 7'd45;
  localparam logic [6:0] ASCII_NONE   = 7'd0;

  localparam logic [3:0] DIGIT_TEN = 4'd10;

  // How one accepted value is to be handled by the back end.
  typedef enum logic [1:0] {
    KIND_ZERO,
    KIND_BAD,
    KIND_NUM
  } kind_t;

  // Control part of one queued job.
  typedef struct packed {
    kind_t      kind;
    logic       neg10;
    logic [4:0] radix;
  } desc_ctl_t;

  // Map a digit value to its ASCII character.
  function automatic logic [6:0] digit_to_ascii(input logic [3:0] d);
    logic [6:0] base;
    base = (d < DIGIT_TEN) ? ASCII_ZERO : ASCII_LETTER;
    return base + {3'b000, d};
  endfunction

endpackage

@@ design/integer_to_radix_text.sv @@
// Channel   Direction  Handshake                 Payload
// input     in         start, busy               in_value
// result    out        out_strobe (one cycle)    out_character, out_final_char, out_bad_radix
// config    in         cfg_write_en              cfg_write_data (radix)
//
// Zero or a bad base gives its one result through the job queue and the
// output register. Otherwise the divider yields each digit at four quotient
// bits a cycle, then characters leave one a cycle. A two-entry job queue
// lets busy rise only while it is full. Reset is synchronous, active low;
// the receiver cannot stall, so results never wait.
`include "integer_to_radix_text_assert.svh"

module integer_to_radix_text #(
  parameter int WORD_BITS = itrt_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_write_en,
  input  logic [7:0]                  cfg_write_data,
  input  logic                        start,
  input  logic signed [WORD_BITS-1:0] in_value,
  output logic                        busy,
  output logic                        out_strobe,
  output logic [6:0]                  out_character,
  output logic                        out_final_char,
  output logic                        out_bad_radix
);

  localparam int CTLW = $bits(itrt_pkg::desc_ctl_t);
  localparam int QW   = CTLW + WORD_BITS;

  logic                 q_push;
  logic                 q_pop;
  logic                 q_full;
  logic                 q_empty;
  itrt_pkg::desc_ctl_t  f_ctl;
  logic [WORD_BITS-1:0] f_mag;
  logic [QW-1:0]        q_wdata;
  logic [QW-1:0]        q_rdata;
  itrt_pkg::desc_ctl_t  b_ctl;
  logic [WORD_BITS-1:0] b_mag;
  logic                 bad_char_ok;
  logic                 minus_seen;
  logic                 q_misuse;

  itrt_front #(.WORD_BITS(WORD_BITS)) u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data),
    .start          (start),
    .in_value       (in_value),
    .q_full         (q_full),
    .busy           (busy),
    .push           (q_push),
    .push_ctl       (f_ctl),
    .push_mag       (f_mag)
  );

  // Pack and unpack queued jobs
  assign q_wdata = {f_ctl, f_mag};
  assign b_ctl   = itrt_pkg::desc_ctl_t'(q_rdata[QW-1 -: CTLW]);
  assign b_mag   = q_rdata[WORD_BITS-1:0];

  itrt_queue #(.WIDTH(QW)) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  itrt_back #(.WORD_BITS(WORD_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .job_ctl        (b_ctl),
    .job_mag        (b_mag),
    .pop            (q_pop),
    .out_strobe     (out_strobe),
    .out_character  (out_character),
    .out_final_char (out_final_char),
    .out_bad_radix  (out_bad_radix)
  );

  // Terms for the checks below
  assign bad_char_ok = out_strobe && out_final_char && (out_character == itrt_pkg::ASCII_NONE);
  assign minus_seen  = out_strobe && (out_character == itrt_pkg::ASCII_MINUS);
  assign q_misuse    = (q_push && q_full) || (q_pop && q_empty);

  // Error result is always a single, final, empty character
  `ITRT_ASSERT_SAME(a_bad_final, clk, rst_n, out_bad_radix, bad_char_ok)
  // A minus sign is never the last character
  `ITRT_ASSERT_SAME(a_minus_not_last, clk, rst_n, minus_seen, !out_final_char)
  // Flags stay low between transfers
  `ITRT_ASSERT_SAME(a_flags_quiet, clk, rst_n, !out_strobe, !out_final_char && !out_bad_radix)
  // A full queue is never pushed and an empty one is never popped
  `ITRT_ASSERT_SAME(a_queue_flow, clk, rst_n, q_push || q_pop, !q_misuse)
  // A pop from a full queue frees a slot by the next cycle
  `ITRT_ASSERT_NEXT(a_busy_clears, clk, rst_n, q_pop && q_full, !busy)

endmodule

@@ design/itrt_front.sv @@
module itrt_front #(
  parameter int WORD_BITS = itrt_pkg::WORD_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_write_en,
  input  logic [7:0]                  cfg_write_data,
  input  logic                        start,
  input  logic signed [WORD_BITS-1:0] in_value,
  input  logic                        q_full,
  output logic                        busy,
  output logic                        push,
  output itrt_pkg::desc_ctl_t         push_ctl,
  output logic [WORD_BITS-1:0]        push_mag
);

  logic [7:0]           radix_r;
  logic [WORD_BITS-1:0] word;
  logic                 negative;
  logic                 word_zero;
  logic                 radix_bad;

  // Hold the base register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= itrt_pkg::RADIX_RESET;
    end else if (cfg_write_en) begin
      radix_r <= cfg_write_data;
    end
  end

  // Classify the incoming value
  assign word      = $unsigned(in_value);
  assign negative  = word[WORD_BITS-1];
  assign word_zero = (word == '0);
  assign radix_bad = (radix_r < itrt_pkg::RADIX_MIN) || (radix_r > itrt_pkg::RADIX_MAX);

  always_comb begin
    if (word_zero) begin
      push_ctl.kind = itrt_pkg::KIND_ZERO;
    end else if (radix_bad) begin
      push_ctl.kind = itrt_pkg::KIND_BAD;
    end else begin
      push_ctl.kind = itrt_pkg::KIND_NUM;
    end
    push_ctl.neg10 = negative && (radix_r == itrt_pkg::RADIX_DEC);
    push_ctl.radix = radix_r[4:0];
  end

  // Magnitude, exact for the most negative value
  assign push_mag = negative ? (~word + WORD_BITS'(1)) : word;

  // Transfer into the queue while it has room
  assign busy = q_full;
  assign push = start && !q_full;

endmodule

@@ design/itrt_queue.sv @@
module itrt_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             full,
  output logic             empty
);

  localparam int DEPTH = itrt_pkg::QUEUE_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] entry_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r;
  logic [PW-1:0]    rd_ptr_r;
  logic [CW-1:0]    count_r;

  assign full     = (count_r == CW'(DEPTH));
  assign empty    = (count_r == '0);
  assign pop_data = entry_r[rd_ptr_r];

  // Store entries
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  // Advance pointers and count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + CW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - CW'(1);
      end
    end
  end

endmodule

@@ design/itrt_back.sv @@
module itrt_back #(
  parameter int WORD_BITS = itrt_pkg::WORD_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_empty,
  input  itrt_pkg::desc_ctl_t  job_ctl,
  input  logic [WORD_BITS-1:0] job_mag,
  output logic                 pop,
  output logic                 out_strobe,
  output logic [6:0]           out_character,
  output logic                 out_final_char,
  output logic                 out_bad_radix
);

  localparam int AW       = $clog2(WORD_BITS);
  localparam int DIV_BITS = ((WORD_BITS + 3) / 4) * 4;
  localparam int STEPS    = DIV_BITS / 4;
  localparam int SW       = $clog2(STEPS);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SIGN,
    ST_EMIT
  } state_t;

  state_t              state_r;
  logic [DIV_BITS-1:0] div_r;
  logic [3:0]          rem_r;
  logic [SW-1:0]       step_r;
  logic [4:0]          radix_r;
  logic                neg10_r;
  logic [AW-1:0]       digit_cnt_r;
  logic [AW-1:0]       rd_ptr_r;
  logic                rd_valid_r;
  logic                rd_last_r;
  logic [3:0]          rd_digit_r;
  logic                out_strobe_r;
  logic [6:0]          out_character_r;
  logic                out_final_r;
  logic                out_bad_r;
  logic [3:0]          digit_mem [WORD_BITS];

  logic [3:0]          rem_nxt;
  logic [DIV_BITS-1:0] quot_nxt;
  logic                last_step;
  logic                mem_we;

  // Four restoring division steps per cycle
  always_comb begin
    logic [4:0] part;
    logic [3:0] qbits;
    part  = {1'b0, rem_r};
    qbits = '0;
    for (int i = 0; i < 4; i++) begin
      part = {part[3:0], div_r[DIV_BITS-1-i]};
      if (part >= radix_r) begin
        part         = part - radix_r;
        qbits[3-i]   = 1'b1;
      end
    end
    rem_nxt  = part[3:0];
    quot_nxt = {div_r[DIV_BITS-5:0], qbits};
  end

  assign last_step = (step_r == SW'(STEPS - 1));
  assign mem_we    = (state_r == ST_DIVIDE) && last_step;
  assign pop       = (state_r == ST_IDLE) && !q_empty && !rd_valid_r;

  // Digit store, least significant digit first
  always_ff @(posedge clk) begin
    if (mem_we) begin
      digit_mem[digit_cnt_r] <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rd_digit_r <= digit_mem[rd_ptr_r];
  end

  // Sequencer and output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      rd_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      out_final_r  <= 1'b0;
      out_bad_r    <= 1'b0;
    end else begin
      rd_valid_r   <= 1'b0;
      out_strobe_r <= 1'b0;
      out_final_r  <= 1'b0;
      out_bad_r    <= 1'b0;

      // Drive a digit read from the store
      if (rd_valid_r) begin
        out_strobe_r    <= 1'b1;
        out_character_r <= itrt_pkg::digit_to_ascii(rd_digit_r);
        out_final_r     <= rd_last_r;
      end

      unique case (state_r)
        ST_IDLE: begin
          if (pop) begin
            unique case (job_ctl.kind)
              itrt_pkg::KIND_ZERO: begin
                out_strobe_r    <= 1'b1;
                out_character_r <= itrt_pkg::ASCII_ZERO;
                out_final_r     <= 1'b1;
              end
              itrt_pkg::KIND_BAD: begin
                out_strobe_r    <= 1'b1;
                out_character_r <= itrt_pkg::ASCII_NONE;
                out_final_r     <= 1'b1;
                out_bad_r       <= 1'b1;
              end
              default: begin
                div_r       <= DIV_BITS'(job_mag);
                rem_r       <= '0;
                step_r      <= '0;
                radix_r     <= job_ctl.radix;
                neg10_r     <= job_ctl.neg10;
                digit_cnt_r <= '0;
                state_r     <= ST_DIVIDE;
              end
            endcase
          end
        end
        ST_DIVIDE: begin
          if (last_step) begin
            rem_r  <= '0;
            step_r <= '0;
            div_r  <= quot_nxt;
            if (quot_nxt == '0) begin
              rd_ptr_r <= digit_cnt_r;
              state_r  <= neg10_r ? ST_SIGN : ST_EMIT;
            end else begin
              digit_cnt_r <= digit_cnt_r + AW'(1);
            end
          end else begin
            div_r  <= quot_nxt;
            rem_r  <= rem_nxt;
            step_r <= step_r + SW'(1);
          end
        end
        ST_SIGN: begin
          out_strobe_r    <= 1'b1;
          out_character_r <= itrt_pkg::ASCII_MINUS;
          state_r         <= ST_EMIT;
        end
        ST_EMIT: begin
          rd_valid_r <= 1'b1;
          rd_last_r  <= (rd_ptr_r == '0);
          if (rd_ptr_r == '0) begin
            state_r <= ST_IDLE;
          end else begin
            rd_ptr_r <= rd_ptr_r - AW'(1);
          end
        end
        default: begin
          state_r <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_strobe     = out_strobe_r;
  assign out_character  = out_character_r;
  assign out_final_char = out_final_r;
  assign out_bad_radix  = out_bad_r;

endmodule
